[src/assert_macros.svh]
// Assertion helpers shared by the RTL. Both forms take a label, the clock,
// a synchronous active-high reset that disables the check, and a message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// The property must hold at every rising clock edge outside reset.
`define BURS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// The expression must never be true at a rising clock edge outside reset.
`define BURS_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define BURS_ASSERT(label, clk, rst, prop, msg)
`define BURS_NEVER(label, clk, rst, expr, msg)
`endif
`endif

[src/burs_pkg.sv]
package burs_pkg;

  // Width of every payload field on the ports.
  localparam int FIELD_W = 32;
  // Default internal word width of the sampler.
  localparam int WORD_WIDTH_DEF = 32;
  // Width of the configuration register index.
  localparam int CFG_INDEX_W = 8;

  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

  localparam cfg_index_t REG_RANGE_LOW     = cfg_index_t'(0);
  localparam cfg_index_t REG_RANGE_HIGH    = cfg_index_t'(1);
  localparam cfg_index_t REG_SIGNED_BOUNDS = cfg_index_t'(2);

  // How an item is mapped into the interval, fixed by the bounds.
  typedef enum logic [1:0] {
    MODE_ERR   = 2'd0,  // low exceeds high
    MODE_POINT = 2'd1,  // low equals high
    MODE_MASK  = 2'd2,  // interval size is a power of two
    MODE_MOD   = 2'd3   // rejection plus remainder
  } mode_t;

endpackage

[src/burs_if.sv]
// Random word channel.
interface burs_word_if;
  logic                          valid;
  logic                          ready;
  logic [burs_pkg::FIELD_W-1:0]  random_word;

  modport source (output valid, output random_word, input ready);
  modport sink   (input valid, input random_word, output ready);
endinterface

// Sample result channel.
interface burs_sample_if;
  logic                          valid;
  logic                          ready;
  logic [burs_pkg::FIELD_W-1:0]  sample_value;
  logic                          accepted;
  logic                          bounds_error;

  modport source (output valid, output sample_value, output accepted,
                  output bounds_error, input ready);
  modport sink   (input valid, input sample_value, input accepted,
                  input bounds_error, output ready);
endinterface

// Configuration write channel.
interface burs_cfg_if;
  logic                          valid;
  logic                          ready;
  burs_pkg::cfg_index_t          index;
  logic [burs_pkg::FIELD_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[src/bounded_uniform_range_sampler_unit.sv]
// A word accepted on the word channel passes through stage 0, one remainder stage per
// word bit and the output register before it leaves on the output channel.
// Throughput: one word per cycle once the bounds are settled and samples are taken.
// Bubbles close up under stall. After reset and after every configuration write the
// word channel is held not ready while the remainder unit derives the acceptance limit.
// Reset is synchronous and active high; it restores the bounds to the full unsigned range.
`include "assert_macros.svh"

module bounded_uniform_range_sampler_unit #(
  parameter int WORD_WIDTH = burs_pkg::WORD_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  burs_word_if.sink            words,
  burs_sample_if.source        samples,
  burs_cfg_if.sink             cfg
);

  localparam int FW    = burs_pkg::FIELD_W;
  localparam int CNT_W = $clog2(WORD_WIDTH + 1);

  // The upper bound resets to all ones across the field width, cut to the
  // word width.
  localparam logic [FW+WORD_WIDTH-1:0] HIGH_RESET_WIDE = {{WORD_WIDTH{1'b0}}, {FW{1'b1}}};

  // One restoring-division step: shift in one dividend bit and subtract the
  // divisor when the partial remainder reaches it.
  function automatic logic [WORD_WIDTH-1:0] rem_step(
    input logic [WORD_WIDTH-1:0] rem,
    input logic                  din,
    input logic [WORD_WIDTH-1:0] div
  );
    logic [WORD_WIDTH:0] shifted;
    logic [WORD_WIDTH:0] diff;
    shifted = {rem, din};
    diff    = shifted - {1'b0, div};
    if (shifted >= {1'b0, div}) begin
      rem_step = diff[WORD_WIDTH-1:0];
    end else begin
      rem_step = shifted[WORD_WIDTH-1:0];
    end
  endfunction

  // ---------------------------------------------------------------------
  // Configuration registers. Field bits above the word width are dropped;
  // a narrower field is zero extended.
  // ---------------------------------------------------------------------
  logic [FW+WORD_WIDTH-1:0] cfg_data_wide;
  logic [WORD_WIDTH-1:0]    cfg_data_word;
  logic [WORD_WIDTH-1:0]    range_low;
  logic [WORD_WIDTH-1:0]    range_high;
  logic                     signed_bounds;
  logic                     cfg_write;

  assign cfg.ready     = 1'b1;
  assign cfg_write     = cfg.valid && cfg.ready;
  assign cfg_data_wide = {{WORD_WIDTH{1'b0}}, cfg.data};
  assign cfg_data_word = cfg_data_wide[WORD_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      range_low     <= '0;
      range_high    <= HIGH_RESET_WIDE[WORD_WIDTH-1:0];
      signed_bounds <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg.index)
        burs_pkg::REG_RANGE_LOW:     range_low     <= cfg_data_word;
        burs_pkg::REG_RANGE_HIGH:    range_high    <= cfg_data_word;
        burs_pkg::REG_SIGNED_BOUNDS: signed_bounds <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Derived bounds. In the first cycle after reset or a write the bounds
  // are classified and the span registered. Then the remainder unit
  // walks the bits of 2^WORD_WIDTH, one per cycle, to get 2^N mod W. The
  // acceptance limit D*W - 1 equals 2^N - 1 - (2^N mod W), its complement.
  // Signed bounds are ordered by flipping their top bit.
  // ---------------------------------------------------------------------
  logic [WORD_WIDTH-1:0] low_ord;
  logic [WORD_WIDTH-1:0] high_ord;
  logic [WORD_WIDTH-1:0] span_next;
  logic [WORD_WIDTH-1:0] w_next;
  burs_pkg::mode_t       mode_next;

  logic                  calc_start;
  logic                  calc_busy;
  logic [CNT_W-1:0]      calc_cnt;
  logic [WORD_WIDTH-1:0] calc_rem;
  logic [WORD_WIDTH-1:0] calc_rem_next;
  logic                  calc_last;

  burs_pkg::mode_t       mode;
  logic [WORD_WIDTH-1:0] span;
  logic [WORD_WIDTH-1:0] w;
  logic [WORD_WIDTH-1:0] accept_limit;

  assign low_ord   = range_low  ^ {signed_bounds, {(WORD_WIDTH-1){1'b0}}};
  assign high_ord  = range_high ^ {signed_bounds, {(WORD_WIDTH-1){1'b0}}};
  assign span_next = high_ord - low_ord;
  assign w_next    = span_next + 1'b1;

  always_comb begin
    if (low_ord > high_ord) begin
      mode_next = burs_pkg::MODE_ERR;
    end else if (low_ord == high_ord) begin
      mode_next = burs_pkg::MODE_POINT;
    end else if ((span_next & w_next) == '0) begin
      // Also catches the full range, where span+1 wraps to zero.
      mode_next = burs_pkg::MODE_MASK;
    end else begin
      mode_next = burs_pkg::MODE_MOD;
    end
  end

  // The dividend 2^N is a one followed by N zeros.
  assign calc_rem_next = rem_step(calc_rem, calc_cnt == '0, w);
  assign calc_last     = calc_cnt == CNT_W'(WORD_WIDTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      calc_start   <= 1'b1;
      calc_busy    <= 1'b0;
      accept_limit <= '1;
    end else begin
      calc_start <= cfg_write;
      if (calc_start) begin
        calc_busy <= 1'b1;
      end else if (calc_busy && calc_last) begin
        calc_busy    <= 1'b0;
        accept_limit <= (mode == burs_pkg::MODE_MOD) ? ~calc_rem_next : '1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (calc_start) begin
      mode     <= mode_next;
      span     <= span_next;
      w        <= w_next;
      calc_cnt <= '0;
      calc_rem <= '0;
    end else if (calc_busy) begin
      calc_cnt <= calc_cnt + 1'b1;
      calc_rem <= calc_rem_next;
    end
  end

  // ---------------------------------------------------------------------
  // Sample pipeline. Stage 0 registers the word and its rejection flag.
  // Stage k retires dividend bit N-k of word mod W. Each stage moves on
  // when the next one is empty or moving, so bubbles close up under stall.
  // ---------------------------------------------------------------------
  logic [FW+WORD_WIDTH-1:0] word_in_wide;
  logic [WORD_WIDTH-1:0]    word_in;
  logic [WORD_WIDTH:0]      st_valid;
  logic [WORD_WIDTH:0]      st_ready;
  logic [WORD_WIDTH:0]      st_rej;
  logic [WORD_WIDTH-1:0]    st_word [0:WORD_WIDTH];
  logic [WORD_WIDTH-1:0]    st_rem  [0:WORD_WIDTH];
  logic                     word_take;

  assign word_in_wide = {{WORD_WIDTH{1'b0}}, words.random_word};
  assign word_in      = word_in_wide[WORD_WIDTH-1:0];
  assign words.ready  = st_ready[0] && !calc_start && !calc_busy;
  assign word_take    = words.valid && words.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid[0] <= 1'b0;
    end else if (st_ready[0]) begin
      st_valid[0] <= word_take;
    end
  end

  always_ff @(posedge clk) begin
    if (st_ready[0]) begin
      st_word[0] <= word_in;
      st_rem[0]  <= '0;
      st_rej[0]  <= word_in > accept_limit;
    end
  end

  for (genvar k = 1; k <= WORD_WIDTH; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        st_valid[k] <= 1'b0;
      end else if (st_ready[k]) begin
        st_valid[k] <= st_valid[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (st_ready[k]) begin
        st_word[k] <= st_word[k-1];
        st_rej[k]  <= st_rej[k-1];
        st_rem[k]  <= rem_step(st_rem[k-1], st_word[k-1][WORD_WIDTH-k], w);
      end
    end
  end

  for (genvar k = 0; k < WORD_WIDTH; k++) begin : g_ready
    assign st_ready[k] = !st_valid[k] || st_ready[k+1];
  end

  // ---------------------------------------------------------------------
  // Output register: the final add of low and the choice by mode.
  // ---------------------------------------------------------------------
  logic                     out_valid;
  logic [FW-1:0]            out_value;
  logic                     out_accepted;
  logic                     out_error;
  logic                     out_take;
  logic [WORD_WIDTH-1:0]    value_next;
  logic                     accepted_next;
  logic                     error_next;
  logic [FW+WORD_WIDTH-1:0] value_wide;

  assign out_take             = !out_valid || samples.ready;
  assign st_ready[WORD_WIDTH] = out_take;

  always_comb begin
    value_next    = '0;
    accepted_next = 1'b1;
    error_next    = 1'b0;
    case (mode)
      burs_pkg::MODE_ERR: begin
        accepted_next = 1'b0;
        error_next    = 1'b1;
      end
      burs_pkg::MODE_POINT: begin
        value_next = range_low;
      end
      burs_pkg::MODE_MASK: begin
        value_next = range_low + (st_word[WORD_WIDTH] & span);
      end
      burs_pkg::MODE_MOD: begin
        if (st_rej[WORD_WIDTH]) begin
          accepted_next = 1'b0;
        end else begin
          value_next = range_low + st_rem[WORD_WIDTH];
        end
      end
      default: begin
        accepted_next = 1'b0;
      end
    endcase
  end

  assign value_wide = {{FW{1'b0}}, value_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_take) begin
      out_valid <= st_valid[WORD_WIDTH];
    end
  end

  always_ff @(posedge clk) begin
    if (out_take) begin
      out_value    <= value_wide[FW-1:0];
      out_accepted <= accepted_next;
      out_error    <= error_next;
    end
  end

  assign samples.valid        = out_valid;
  assign samples.sample_value = out_value;
  assign samples.accepted     = out_accepted;
  assign samples.bounds_error = out_error;

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
  `BURS_ASSERT(a_cfg_blocks_words, clk, rst, cfg_write |=> !words.ready, "word after write")
  `BURS_NEVER(a_acc_and_err, clk, rst, out_valid && out_accepted && out_error, "both flags set")
  `BURS_ASSERT(a_busy_from_start, clk, rst, $rose(calc_busy) |-> $past(calc_start), "stray busy")

endmodule
